// ----- rtl/core/rtfb_pkg.sv -----
// ----------------------------------------------------------------------------
// rtfb_pkg
// shared types, codes and color helpers for the tri-color framebuffer
// ----------------------------------------------------------------------------
`default_nettype none

package rtfb_pkg;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_MEM,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		TONE_WHITE,
		TONE_BLACK,
		TONE_RED
	} tone_t;

	// item function codes
	localparam logic [1:0] FUNC_PIXEL = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	// config register indexes
	localparam logic CFG_DARK  = 1'b0;
	localparam logic CFG_LIGHT = 1'b1;

	localparam logic [7:0] DARK_RESET  = 8'd85;
	localparam logic [7:0] LIGHT_RESET = 8'd180;
	localparam logic [7:0] BLANK_BYTE  = 8'hFF;

	// luma weights, sum of the three is 65536
	localparam logic [23:0] LUMA_R = 24'd19595;
	localparam logic [23:0] LUMA_G = 24'd38470;
	localparam logic [23:0] LUMA_B = 24'd7471;

	// width for address arithmetic over the whole parameter range
	localparam int CALC_W = 17;

	// v*255/31 truncated: 8*v plus floor(7*v/31)
	function automatic logic [7:0] expand5(input logic [4:0] v);
		logic [7:0] e;
		e = {v, 3'b000}
			+ 8'(v >= 5'd5) + 8'(v >= 5'd9) + 8'(v >= 5'd14) + 8'(v >= 5'd18)
			+ 8'(v >= 5'd23) + 8'(v >= 5'd27) + 8'(v >= 5'd31);
		return e;
	endfunction

	// v*255/63 truncated: 4*v plus floor(v/21)
	function automatic logic [7:0] expand6(input logic [5:0] v);
		logic [7:0] e;
		e = {v, 2'b00} + 8'(v >= 6'd21) + 8'(v >= 6'd42) + 8'(v == 6'd63);
		return e;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rtfb_plane_ram.sv -----
// ----------------------------------------------------------------------------
// rtfb_plane_ram
// one bit plane: byte wide, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rtfb_plane_ram #(
	parameter int DEPTH = 2756,
	parameter int AW    = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/rtfb_pixel_classify.sv -----
// ----------------------------------------------------------------------------
// rtfb_pixel_classify
// rgb565 to 8-bit luma, then black / white / red by two thresholds
// ----------------------------------------------------------------------------
`default_nettype none

module rtfb_pixel_classify (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [15:0]   rgb,
	input  wire logic [7:0]    dark,
	input  wire logic [7:0]    light,
	output rtfb_pkg::tone_t    tone_q
);

	logic [7:0]      r8;
	logic [7:0]      g8;
	logic [7:0]      b8;
	logic [23:0]     sum;
	logic [7:0]      luma;
	rtfb_pkg::tone_t tone_d;

	always_comb begin
		r8   = rtfb_pkg::expand5(rgb[15:11]);
		g8   = rtfb_pkg::expand6(rgb[10:5]);
		b8   = rtfb_pkg::expand5(rgb[4:0]);
		sum  = 24'(r8) * rtfb_pkg::LUMA_R + 24'(g8) * rtfb_pkg::LUMA_G
			+ 24'(b8) * rtfb_pkg::LUMA_B;
		luma = sum[23:16];
		// dark test first, so it wins when thresholds cross
		if (luma < dark) begin
			tone_d = rtfb_pkg::TONE_BLACK;
		end else if (luma > light) begin
			tone_d = rtfb_pkg::TONE_WHITE;
		end else begin
			tone_d = rtfb_pkg::TONE_RED;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tone_q <= tone_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/rgb565_tricolor_epaper_framebuffer_unit.sv -----
// ----------------------------------------------------------------------------
// rgb565_tricolor_epaper_framebuffer_unit
// two-plane tri-color e-paper framebuffer with an rgb565 pixel front end
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) takes one item: func selects a pixel
//   write, a byte read or a clear of the whole store. output channel
//   (out_valid/out_ready) returns read_data for read items only.
//   cfg_we/cfg_index/cfg_data write the dark or the light threshold, as cfg_index selects.
// timing:
//   each item passes through the sequencer steps in order (accept, address and
//   luma, memory read, write-back or result), and no new item is accepted
//   until it is through; the read-modify-write on the plane memories needs these steps.
//   a read result is registered into the output slot in its last step.
//   a clear item rewrites PANEL_WIDTH*PANEL_HEIGHT/8 bytes (2756 by default)
//   in each plane after its accept cycle, one byte of both planes per cycle.
// reset:
//   thresholds return to 85 and 180 and the block runs the same fill pass
//   over the store before it takes its first item; config writes are taken
//   during the pass.
// stall:
//   the result sits in an output register; the next item is accepted while
//   it waits, and a later read holds in its last step until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_tricolor_epaper_framebuffer_unit #(
	parameter int PANEL_WIDTH  = 104,
	parameter int PANEL_HEIGHT = 212
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// item channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [8:0]  x_pos,
	input  wire logic [8:0]  y_pos,
	input  wire logic [15:0] pixel_rgb565,
	input  wire logic [12:0] byte_index,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [7:0]  read_data,
	// config port
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);

	localparam int ROW_BYTES   = PANEL_WIDTH / 8;
	localparam int PLANE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT) / 8;
	localparam int STORE_BYTES = 2 * PLANE_BYTES;
	localparam int AW          = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;
	localparam int CW          = rtfb_pkg::CALC_W;

	// sequencer and item registers
	rtfb_pkg::state_t state_q;
	rtfb_pkg::state_t state_d;
	logic [AW-1:0]    clr_q;
	logic [1:0]       func_q;
	logic [8:0]       x_q;
	logic [8:0]       y_q;
	logic [15:0]      rgb_q;
	logic [12:0]      idx_q;

	// resolved access
	logic [AW-1:0]    addr_q;
	logic             bank_q;   // read from red plane
	logic             hit_q;    // pixel on panel / read index in store
	logic [7:0]       mask_q;
	rtfb_pkg::tone_t  tone_q;

	logic [7:0]       dark_q;
	logic [7:0]       light_q;
	logic             out_valid_q;
	logic [7:0]       read_data_q;

	logic             accept;
	logic             calc_en;
	logic             load_out;
	logic             mem_re;
	logic             mem_we;
	logic             clr_last;
	logic [AW-1:0]    waddr;
	logic [7:0]       bw_rd;
	logic [7:0]       red_rd;
	logic [7:0]       bw_wr;
	logic [7:0]       red_wr;

	// address arithmetic
	logic [9:0]       row;
	logic [CW-1:0]    pix_addr;
	logic             on_panel;
	logic [CW-1:0]    idx_w;
	logic             idx_red;
	logic [CW-1:0]    rd_addr;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == rtfb_pkg::ST_IDLE);
	assign calc_en   = (state_q == rtfb_pkg::ST_CALC);
	assign mem_re    = (state_q == rtfb_pkg::ST_MEM);
	assign clr_last  = (clr_q == AW'(PLANE_BYTES - 1));
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	// next state and datapath controls
	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		case (state_q)
			rtfb_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = rtfb_pkg::ST_IDLE;
				end
			end
			rtfb_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (func == rtfb_pkg::FUNC_CLEAR) ? rtfb_pkg::ST_CLEAR
						: rtfb_pkg::ST_CALC;
				end
			end
			rtfb_pkg::ST_CALC: begin
				state_d = rtfb_pkg::ST_MEM;
			end
			rtfb_pkg::ST_MEM: begin
				state_d = rtfb_pkg::ST_DONE;
			end
			rtfb_pkg::ST_DONE: begin
				if (func_q == rtfb_pkg::FUNC_READ) begin
					// hold the read until the output slot is free
					if (!out_valid_q || out_ready) begin
						load_out = 1'b1;
						state_d  = rtfb_pkg::ST_IDLE;
					end
				end else begin
					state_d = rtfb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rtfb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtfb_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == rtfb_pkg::ST_CLEAR) begin
				clr_q <= clr_last ? '0 : clr_q + AW'(1);
			end
		end
	end

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_q  <= rtfb_pkg::DARK_RESET;
			light_q <= rtfb_pkg::LIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rtfb_pkg::CFG_DARK:  dark_q  <= cfg_data;
				rtfb_pkg::CFG_LIGHT: light_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// capture the item
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			x_q    <= x_pos;
			y_q    <= y_pos;
			rgb_q  <= pixel_rgb565;
			idx_q  <= byte_index;
		end
	end

	// rotated panel address: column = y, row = height-1-x
	always_comb begin
		on_panel = (10'(x_q) < 10'(PANEL_HEIGHT)) && (10'(y_q) < 10'(PANEL_WIDTH));
		row      = 10'(PANEL_HEIGHT - 1) - 10'(x_q);
		pix_addr = CW'(row) * CW'(ROW_BYTES) + CW'(y_q[8:3]);
		idx_w    = CW'(idx_q);
		idx_red  = (idx_w >= CW'(PLANE_BYTES));
		rd_addr  = idx_red ? (idx_w - CW'(PLANE_BYTES)) : idx_w;
	end

	always_ff @(posedge clk) begin
		if (calc_en) begin
			mask_q <= 8'h80 >> y_q[2:0];
			if (func_q == rtfb_pkg::FUNC_READ) begin
				addr_q <= AW'(rd_addr);
				bank_q <= idx_red;
				hit_q  <= (idx_w < CW'(STORE_BYTES));
			end else begin
				addr_q <= AW'(pix_addr);
				bank_q <= 1'b0;
				// address past the plane happens when width is not a multiple of 8
				hit_q  <= on_panel && (pix_addr < CW'(PLANE_BYTES));
			end
		end
	end

	rtfb_pixel_classify u_classify (
		.clk    (clk),
		.en     (calc_en),
		.rgb    (rgb_q),
		.dark   (dark_q),
		.light  (light_q),
		.tone_q (tone_q)
	);

	// modify: set both bits, then clear the one the tone picks (none for white); a clear writes blank bytes
	always_comb begin
		bw_wr  = bw_rd | mask_q;
		red_wr = red_rd | mask_q;
		if (state_q == rtfb_pkg::ST_CLEAR) begin
			bw_wr  = rtfb_pkg::BLANK_BYTE;
			red_wr = rtfb_pkg::BLANK_BYTE;
		end else if (tone_q == rtfb_pkg::TONE_BLACK) begin
			bw_wr = bw_wr & ~mask_q;
		end else if (tone_q == rtfb_pkg::TONE_RED) begin
			red_wr = red_wr & ~mask_q;
		end
	end

	assign mem_we = (state_q == rtfb_pkg::ST_CLEAR)
		|| ((state_q == rtfb_pkg::ST_DONE) && (func_q == rtfb_pkg::FUNC_PIXEL) && hit_q);
	assign waddr  = (state_q == rtfb_pkg::ST_CLEAR) ? clr_q : addr_q;

	rtfb_plane_ram #(
		.DEPTH (PLANE_BYTES),
		.AW    (AW)
	) u_bw_plane (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (bw_wr),
		.re    (mem_re),
		.raddr (addr_q),
		.rdata (bw_rd)
	);

	rtfb_plane_ram #(
		.DEPTH (PLANE_BYTES),
		.AW    (AW)
	) u_red_plane (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (red_wr),
		.re    (mem_re),
		.raddr (addr_q),
		.rdata (red_rd)
	);

	// output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			// index beyond the store reads as blank paper
			read_data_q <= !hit_q ? rtfb_pkg::BLANK_BYTE : (bank_q ? red_rd : bw_rd);
		end
	end

endmodule

`default_nettype wire
